// ===== rtl/core/kar_pkg.sv =====
// Shared types and constants for the key auto-repeat block.
package kar_pkg;

  localparam int unsigned KeyW   = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;

  // Configuration register indexes
  localparam logic CfgFirstDelay  = 1'b0;
  localparam logic CfgRepeatDelay = 1'b1;

  localparam logic [DelayW-1:0] FirstDelayRst  = 16'h0200;
  localparam logic [DelayW-1:0] RepeatDelayRst = 16'h0050;

  // Per-key state word
  typedef struct packed {
    logic             held;
    logic             repeating;
    logic [TimeW-1:0] last_fire;
  } kar_entry_t;

  // One key sample
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic             down;
    logic             repeat_mode;
    logic [TimeW-1:0] now;
  } kar_item_t;

endpackage

// ===== rtl/core/kar_state_mem.sv =====
// Per-key state memory with valid bits and write-to-read bypass.
module kar_state_mem
  import kar_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned IdxW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output kar_entry_t      rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  kar_entry_t      wr_data_i
);

  kar_entry_t           mem_q [Depth];
  kar_entry_t           rd_q;
  kar_entry_t           byp_data_q;
  logic                 byp_q;
  logic                 rd_valid_q;
  logic [Depth-1:0]     valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        // Take the word being written in the same edge
        byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ===== rtl/core/kar_update.sv =====
// Fire decision and next per-key state for one sample.
module kar_update
  import kar_pkg::*;
(
  input  kar_item_t         item_i,
  input  kar_entry_t        entry_i,
  input  logic [DelayW-1:0] first_delay_i,
  input  logic [DelayW-1:0] repeat_delay_i,
  output logic              fire_o,
  output kar_entry_t        entry_o
);

  logic [DelayW-1:0] delay;
  logic [TimeW-1:0]  elapsed;
  logic              rep_fire;

  always_comb begin
    delay    = entry_i.repeating ? repeat_delay_i : first_delay_i;
    elapsed  = item_i.now - entry_i.last_fire;
    rep_fire = !entry_i.held || (elapsed > {{(TimeW-DelayW){1'b0}}, delay});

    entry_o      = entry_i;
    entry_o.held = item_i.down;
    fire_o       = 1'b0;
    if (!item_i.down) begin
      entry_o.repeating = 1'b0;
    end else if (!item_i.repeat_mode) begin
      fire_o = 1'b1;
    end else if (rep_fire) begin
      fire_o            = 1'b1;
      entry_o.repeating = entry_i.repeating | entry_i.held;
      entry_o.last_fire = item_i.now;
    end
  end

endmodule

// ===== rtl/core/key_auto_repeat_top.sv =====
// Top level of the key auto-repeat block.
//
// Typematic key repeat: every sample word names a key, its down level, a
// repeat-mode flag and a millisecond timestamp, and yields one fire word.
// The block takes one sample per clock and sustains one result per clock
// while out_ready_i holds the result channel open; a sample's result
// reaches fire_o through stage 1 and the output register. That shape is
// set by the per-key state memory, whose read port is registered: the
// accepting edge reads the key's state, and stage 1 then decides, writes
// the state back and loads the output register at the edge that advances
// it. A sample right behind one for the same key gets the freshly written state
// through a bypass. Each memory entry has a valid bit cleared at reset, so
// no clearing pass is needed and samples are taken right after reset.
// Keys at or above KEY_COUNT give fire 0 and leave all state alone.
// Configuration writes (index 0: first delay, index 1: repeat delay) take
// effect on the next edge and must only be made while the block is idle.
module key_auto_repeat_top
  import kar_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  // Sample channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KeyW-1:0]   key_i,
  input  logic              down_i,
  input  logic              repeat_mode_i,
  input  logic [TimeW-1:0]  now_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              fire_o
);

  // Only the first 256 keys are reachable through an 8-bit index
  localparam int unsigned Depth = (KEY_COUNT < (1 << KeyW)) ? KEY_COUNT : (1 << KeyW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DelayW-1:0] first_delay_q;
  logic [DelayW-1:0] repeat_delay_q;

  kar_item_t         s1_item_q;
  logic              s1_valid_q;
  logic              s1_range_q;
  logic              accept;
  logic              advance;
  logic              in_range;

  kar_entry_t        rd_entry;
  kar_entry_t        new_entry;
  logic              fire;
  logic              mem_we;

  logic              out_valid_q;
  logic              fire_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= FirstDelayRst;
      repeat_delay_q <= RepeatDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFirstDelay:  first_delay_q  <= cfg_wdata_i;
        CfgRepeatDelay: repeat_delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 1 moves on when the output register is free or being drained
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(key_i) < KEY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the sample word next to the memory read it launched
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.key         <= key_i;
      s1_item_q.down        <= down_i;
      s1_item_q.repeat_mode <= repeat_mode_i;
      s1_item_q.now         <= now_i;
      s1_range_q            <= in_range;
    end
  end

  kar_state_mem #(
    .Depth (Depth),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (key_i[IdxW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_item_q.key[IdxW-1:0]),
    .wr_data_i (new_entry)
  );

  kar_update u_update (
    .item_i         (s1_item_q),
    .entry_i        (rd_entry),
    .first_delay_i  (first_delay_q),
    .repeat_delay_i (repeat_delay_q),
    .fire_o         (fire),
    .entry_o        (new_entry)
  );

  // Write back only for keys in range
  assign mem_we = advance && s1_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fire_q <= fire && s1_range_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fire_o      = fire_q;

  // Stalled stage 1 must block new samples
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> !in_ready_o)
    else $error("sample accepted while stage 1 stalled");

  // Accepted sample lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted sample lost before stage 1");

  // Memory writes only come from a live stage 1 word
  a_write_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s1_valid_q && s1_range_q))
    else $error("state write without a sample");

  // A released key never fires
  a_release_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !s1_item_q.down) |=> (out_valid_o && !fire_o))
    else $error("fire on a released key");

endmodule
